### sv/value_noise_fbm_3d_defines.svh
// Assertion macros shared by the value noise fBm RTL.
`ifndef VALUE_NOISE_FBM_3D_DEFINES_SVH
`define VALUE_NOISE_FBM_3D_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge outside reset.
`define VNFBM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vnfbm assertion failed");
// Property checked on every rising edge, reset included.
`define VNFBM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("vnfbm assertion failed");
`else
`define VNFBM_ASSERT(lbl, clk, rst, prop)
`define VNFBM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/vnfbm_pkg.sv
// Types, constants and helper functions of the value noise fBm block.
`timescale 1ns / 1ps
package vnfbm_pkg;

   // Widths sized for up to sixteen octaves.
   localparam int SUM_W  = 40;
   localparam int NORM_W = 21;
   localparam int AMP_W  = 17;
   localparam int DEN_W  = NORM_W + 16;
   localparam int REM_W  = SUM_W + 14;
   localparam int QUO_W  = 17;

   // Lattice and hash constants.
   localparam logic [31:0] PRIME_X = 32'd73856093;
   localparam logic [31:0] PRIME_Y = 32'd19349663;
   localparam logic [31:0] PRIME_Z = 32'd83492791;
   localparam logic [31:0] MIX_A   = 32'h27d4eb2d;
   localparam logic [31:0] MIX_B   = 32'h85ebca6b;

   localparam logic [AMP_W-1:0] ONE_Q16  = 17'd65536;
   localparam logic [QUO_W-1:0] QUO_MAX  = 17'd32768;

   typedef enum logic [1:0] {
      REG_SEED    = 2'd0,
      REG_OCTAVES = 2'd1,
      REG_PERSIST = 2'd2,
      REG_LACUN   = 2'd3
   } reg_index_type;

   // One sample travelling along the octave chain.
   typedef struct packed {
      logic                     valid;
      logic                     mode;
      logic [31:0]              px;
      logic [31:0]              py;
      logic [31:0]              pz;
      logic [AMP_W-1:0]         amp;
      logic signed [SUM_W-1:0]  sum;
      logic [NORM_W-1:0]        norm;
   } oct_item_type;

   // One sample travelling along the divider chain.
   typedef struct packed {
      logic              valid;
      logic              neg;
      logic [REM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [QUO_W-1:0]  quo;
   } div_item_type;

   // Linear blend of two Q0.16 values with a weight of up to 1.0.
   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [AMP_W-1:0] w);
      logic [33:0] acc;
      acc = 34'(a) * 34'(ONE_Q16 - w) + 34'(b) * 34'(w);
      return acc[31:16];
   endfunction

   // Floor division by 65535 of a 32-bit value below 65536*65535, by folding and correcting.
   function automatic logic [15:0] div_max(input logic [31:0] x);
      logic [16:0] r0;
      logic [16:0] q;
      r0 = {1'b0, x[15:0]} + {1'b0, x[31:16]};
      q  = {1'b0, x[31:16]} + 17'(r0 >= 17'd65535) + 17'(r0 >= 17'd131070);
      return q[15:0];
   endfunction

endpackage

### sv/vnfbm_octave_cell.sv
// One octave of value noise: hash, smootherstep, trilinear blend, accumulate.
`timescale 1ns / 1ps
module vnfbm_octave_cell #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   cell_on,
   input  logic [31:0]            hash_seed,
   input  logic [15:0]            persistence,
   input  logic [15:0]            lacunarity,
   input  vnfbm_pkg::oct_item_type item_in,
   output vnfbm_pkg::oct_item_type item_out
);

   localparam int NSIDE = 10;

   typedef struct packed {
      logic                               mode;
      logic [vnfbm_pkg::AMP_W-1:0]        amp;
      logic [vnfbm_pkg::AMP_W-1:0]        namp;
      logic [31:0]                        npx;
      logic [31:0]                        npy;
      logic [31:0]                        npz;
      logic signed [vnfbm_pkg::SUM_W-1:0] sum;
      logic [vnfbm_pkg::NORM_W-1:0]       norm;
   } side_type;

   // Signed coordinate times unsigned Q8.8 factor, floored, low 32 bits kept.
   function automatic logic [31:0] scale(input logic [31:0] p, input logic [15:0] lac);
      logic signed [48:0] prod;
      prod = $signed(p) * $signed({1'b0, lac});
      return prod[39:8];
   endfunction

   logic [NSIDE:1]  vld_ff, vld_in;
   side_type        side_ff [1:NSIDE];
   side_type        side_in [1:NSIDE];

   // Fractions brought to Q0.16.
   logic [15:0] tx, ty, tz;
   if (COORD_FRAC_BITS >= 16) begin : g_frac_down
      assign tx = item_in.px[COORD_FRAC_BITS-1 -: 16];
      assign ty = item_in.py[COORD_FRAC_BITS-1 -: 16];
      assign tz = item_in.pz[COORD_FRAC_BITS-1 -: 16];
   end else begin : g_frac_up
      assign tx = {item_in.px[COORD_FRAC_BITS-1:0], {(16-COORD_FRAC_BITS){1'b0}}};
      assign ty = {item_in.py[COORD_FRAC_BITS-1:0], {(16-COORD_FRAC_BITS){1'b0}}};
      assign tz = {item_in.pz[COORD_FRAC_BITS-1:0], {(16-COORD_FRAC_BITS){1'b0}}};
   end

   // Stage 1: cell origin products, fraction squares, next octave scaling.
   logic [31:0] xa_ff, ya_ff, za_ff, xa_in, ya_in, za_in;
   logic [31:0] tt_ff [3], tt_in [3];
   logic [15:0] t_ff [3], t_in [3];
   logic [32:0] amp_prod;

   always_comb begin
      xa_in = 32'($signed(item_in.px) >>> COORD_FRAC_BITS) * vnfbm_pkg::PRIME_X;
      ya_in = 32'($signed(item_in.py) >>> COORD_FRAC_BITS) * vnfbm_pkg::PRIME_Y;
      za_in = 32'($signed(item_in.pz) >>> COORD_FRAC_BITS) * vnfbm_pkg::PRIME_Z;
      t_in[0] = tx;
      t_in[1] = ty;
      t_in[2] = tz;
      for (int i = 0; i < 3; i++) begin
         tt_in[i] = 32'(t_in[i]) * 32'(t_in[i]);
      end
      amp_prod = 33'(item_in.amp) * 33'(persistence);
      side_in[1].mode = item_in.mode;
      side_in[1].amp  = item_in.amp;
      side_in[1].namp = amp_prod[32:16];
      side_in[1].npx  = scale(item_in.px, lacunarity);
      side_in[1].npy  = scale(item_in.py, lacunarity);
      side_in[1].npz  = scale(item_in.pz, lacunarity);
      side_in[1].sum  = item_in.sum;
      side_in[1].norm = item_in.norm;
      for (int k = 2; k <= NSIDE; k++) begin
         side_in[k] = side_ff[k-1];
      end
   end

   // Stage 2: corner keys and the first half of the smootherstep.
   logic [31:0] key_ff [8], key_in [8];
   logic [31:0] t3a_ff [3], t3a_in [3];
   logic [19:0] poly_ff [3], poly_in [3];
   logic [34:0] six;

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         key_in[c] = (c[0] ? xa_ff + vnfbm_pkg::PRIME_X : xa_ff)
                   ^ (c[1] ? ya_ff + vnfbm_pkg::PRIME_Y : ya_ff)
                   ^ (c[2] ? za_ff + vnfbm_pkg::PRIME_Z : za_ff);
      end
      six = '0;
      for (int i = 0; i < 3; i++) begin
         t3a_in[i]  = 32'(tt_ff[i][31:16]) * 32'(t_ff[i]);
         six        = 35'(tt_ff[i]) * 35'd6;
         poly_in[i] = 20'(21'd655360 + 21'(six[34:16]) - 21'(t_ff[i]) * 21'd15);
      end
   end

   // Stage 3: first hash multiply and the capped fade weights.
   logic [31:0] h1_ff [8], h1_in [8];
   logic [vnfbm_pkg::AMP_W-1:0] wt3_ff [3], wt3_in [3];
   logic [35:0] fprod;

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         h1_in[c] = (key_ff[c] ^ hash_seed) * vnfbm_pkg::MIX_A;
      end
      fprod = '0;
      for (int i = 0; i < 3; i++) begin
         fprod     = 36'(t3a_ff[i][31:16]) * 36'(poly_ff[i]);
         wt3_in[i] = (fprod[35:16] > 20'd65536) ? vnfbm_pkg::ONE_Q16 : fprod[32:16];
      end
   end

   // Stage 4: second hash multiply.
   logic [31:0] h2_ff [8], h2_in [8];
   logic [vnfbm_pkg::AMP_W-1:0] wt4_ff [3];

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         h2_in[c] = (h1_ff[c] ^ (h1_ff[c] >> 15)) * vnfbm_pkg::MIX_B;
      end
   end

   // Stage 5: final hash mix and blend along x.
   logic [31:0] hv [8];
   logic [15:0] nx_ff [4], nx_in [4];
   logic [vnfbm_pkg::AMP_W-1:0] wv5_ff, ww5_ff;

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         hv[c] = h2_ff[c] ^ (h2_ff[c] >> 13);
      end
      for (int j = 0; j < 4; j++) begin
         nx_in[j] = vnfbm_pkg::blend(hv[2*j][15:0], hv[2*j+1][15:0], wt4_ff[0]);
      end
   end

   // Stage 6 and 7: blend along y, then along z.
   logic [15:0] ny_ff [2], ny_in [2];
   logic [vnfbm_pkg::AMP_W-1:0] ww6_ff;
   logic [15:0] nz_ff, nz_in;

   always_comb begin
      ny_in[0] = vnfbm_pkg::blend(nx_ff[0], nx_ff[1], wv5_ff);
      ny_in[1] = vnfbm_pkg::blend(nx_ff[2], nx_ff[3], wv5_ff);
      nz_in    = vnfbm_pkg::blend(ny_ff[0], ny_ff[1], ww6_ff);
   end

   // Stage 8: centred value and the square used by the ridged form.
   logic signed [17:0] dw;
   logic [17:0]        dmag;
   logic [15:0]        ridge;
   logic signed [16:0] d_ff, d_in;
   logic [31:0]        rr_ff, rr_in;

   always_comb begin
      dw    = $signed({1'b0, nz_ff, 1'b0}) - 18'sd65535;
      dmag  = dw[17] ? 18'(-dw) : 18'(dw);
      ridge = 16'(18'd65535 - dmag);
      d_in  = 17'(dw);
      rr_in = 32'(ridge) * 32'(ridge);
   end

   // Stage 9 and 10: octave term, then weighting by the amplitude.
   logic signed [16:0] term_ff, term_in;
   logic signed [34:0] prod_ff, prod_in;

   always_comb begin
      term_in = side_ff[8].mode ? $signed({1'b0, vnfbm_pkg::div_max(rr_ff)}) : d_ff;
      prod_in = term_ff * $signed({1'b0, side_ff[9].amp});
   end

   // Stage 11: accumulate when this octave is in use.
   vnfbm_pkg::oct_item_type out_ff, out_in;

   always_comb begin
      out_in.valid = vld_ff[NSIDE];
      out_in.mode  = side_ff[NSIDE].mode;
      out_in.px    = side_ff[NSIDE].npx;
      out_in.py    = side_ff[NSIDE].npy;
      out_in.pz    = side_ff[NSIDE].npz;
      out_in.amp   = side_ff[NSIDE].namp;
      out_in.sum   = side_ff[NSIDE].sum
                   + (cell_on ? vnfbm_pkg::SUM_W'(prod_ff) : '0);
      out_in.norm  = side_ff[NSIDE].norm
                   + (cell_on ? vnfbm_pkg::NORM_W'(side_ff[NSIDE].amp) : '0);
      vld_in       = {vld_ff[NSIDE-1:1], item_in.valid};
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
         out_ff <= out_in;
      end
   end

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         xa_ff   <= xa_in;
         ya_ff   <= ya_in;
         za_ff   <= za_in;
         tt_ff   <= tt_in;
         t_ff    <= t_in;
         key_ff  <= key_in;
         t3a_ff  <= t3a_in;
         poly_ff <= poly_in;
         h1_ff   <= h1_in;
         wt3_ff  <= wt3_in;
         h2_ff   <= h2_in;
         wt4_ff  <= wt3_ff;
         nx_ff   <= nx_in;
         wv5_ff  <= wt4_ff[1];
         ww5_ff  <= wt4_ff[2];
         ny_ff   <= ny_in;
         ww6_ff  <= ww5_ff;
         nz_ff   <= nz_in;
         d_ff    <= d_in;
         rr_ff   <= rr_in;
         term_ff <= term_in;
         prod_ff <= prod_in;
      end
   end

   assign item_out = out_ff;

endmodule

### sv/vnfbm_div_cell.sv
// One restoring step of the normalising divider: decides one quotient bit.
`timescale 1ns / 1ps
module vnfbm_div_cell #(
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  vnfbm_pkg::div_item_type item_in,
   output vnfbm_pkg::div_item_type item_out
);

   vnfbm_pkg::div_item_type out_ff, out_in;
   logic [vnfbm_pkg::REM_W-1:0] cmp;

   // Subtract the shifted divisor where it fits.
   always_comb begin
      cmp    = vnfbm_pkg::REM_W'(item_in.den) << BIT;
      out_in = item_in;
      if (item_in.rem >= cmp) begin
         out_in.rem      = item_in.rem - cmp;
         out_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign item_out = out_ff;

endmodule

### sv/value_noise_fbm_3d.sv
// Top level of the seeded 3D value noise fBm generator.
//
// Requests come in on the req_ stream: three signed coordinates in tdata and
// the mode in tuser (0 classic fBm, 1 ridged fBm). Each request gives exactly
// one result on the rsp_ stream, a saturated Q1.15 noise value, in order.
// The block is a fully pipelined chain: one octave cell of 11 stages per
// octave up to MAX_OCTAVES, then a 17-stage restoring divider, one quotient
// bit per stage. A new request is taken every cycle while the output is not
// stalled. Unused octave cells still pass the sample along, so latency does
// not depend on the octave count.
// The csr_ port writes one register per cycle; writes belong to idle times.
// Reset clears all valid bits and loads the register defaults (seed 0, four
// octaves, persistence 0.5, lacunarity 2.0).
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops until that result is taken.
`timescale 1ns / 1ps
`include "value_noise_fbm_3d_defines.svh"
module value_noise_fbm_3d #(
   parameter int MAX_OCTAVES     = 8,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // coord_x, coord_y, coord_z from bit 0
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // noise_value
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_OCTAVES + 1) + 1;

   // Configuration registers.
   logic [31:0] seed_ff;
   logic [3:0]  count_ff;
   logic [15:0] persist_ff;
   logic [15:0] lacun_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         count_ff   <= 4'd4;
         persist_ff <= 16'd32768;
         lacun_ff   <= 16'd512;
      end else if (csr_wr_en) begin
         unique case (vnfbm_pkg::reg_index_type'(csr_index))
            vnfbm_pkg::REG_SEED:    seed_ff    <= csr_wdata;
            vnfbm_pkg::REG_OCTAVES: count_ff   <= csr_wdata[3:0];
            vnfbm_pkg::REG_PERSIST: persist_ff <= csr_wdata[15:0];
            vnfbm_pkg::REG_LACUN:   lacun_ff   <= csr_wdata[15:0];
            default:                seed_ff    <= seed_ff;
         endcase
      end
   end

   // Octave count held within one and MAX_OCTAVES.
   logic [CNT_W-1:0] cnt_eff;

   always_comb begin
      if (count_ff == 4'd0) begin
         cnt_eff = CNT_W'(1);
      end else if (CNT_W'(count_ff) > CNT_W'(MAX_OCTAVES)) begin
         cnt_eff = CNT_W'(MAX_OCTAVES);
      end else begin
         cnt_eff = CNT_W'(count_ff);
      end
   end

   // The whole pipeline moves unless a finished result is held back.
   logic en;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0] rsp_tdata_ff, rsp_tdata_in;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Input register at the head of the octave chain.
   vnfbm_pkg::oct_item_type in_ff, in_in;

   always_comb begin
      in_in.valid = req_tvalid;
      in_in.mode  = req_tuser;
      in_in.px    = req_tdata[31:0];
      in_in.py    = req_tdata[63:32];
      in_in.pz    = req_tdata[95:64];
      in_in.amp   = vnfbm_pkg::ONE_Q16;
      in_in.sum   = '0;
      in_in.norm  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else if (en) begin
         in_ff <= in_in;
      end
   end

   // Chain of octave cells.
   vnfbm_pkg::oct_item_type link [0:MAX_OCTAVES];
   assign link[0] = in_ff;

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
      logic cell_on;
      assign cell_on = (CNT_W'(k) < cnt_eff);
      vnfbm_octave_cell #(
         .COORD_FRAC_BITS(COORD_FRAC_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .cell_on     (cell_on),
         .hash_seed   (seed_ff),
         .persistence (persist_ff),
         .lacunarity  (lacun_ff),
         .item_in     (link[k]),
         .item_out    (link[k+1])
      );
   end

   // Divider set-up: magnitude of sum*32768 over norm*65535.
   vnfbm_pkg::div_item_type prep_ff, prep_in;
   logic [vnfbm_pkg::SUM_W-1:0] mag;

   always_comb begin
      prep_in.valid = link[MAX_OCTAVES].valid;
      prep_in.neg   = link[MAX_OCTAVES].sum[vnfbm_pkg::SUM_W-1];
      mag           = prep_in.neg ? vnfbm_pkg::SUM_W'(-link[MAX_OCTAVES].sum)
                                  : vnfbm_pkg::SUM_W'(link[MAX_OCTAVES].sum);
      prep_in.rem   = vnfbm_pkg::REM_W'(mag) << 15;
      prep_in.den   = (vnfbm_pkg::DEN_W'(link[MAX_OCTAVES].norm) << 16)
                    - vnfbm_pkg::DEN_W'(link[MAX_OCTAVES].norm);
      prep_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (en) begin
         prep_ff <= prep_in;
      end
   end

   // Chain of divider cells, most significant quotient bit first.
   vnfbm_pkg::div_item_type dlink [0:vnfbm_pkg::QUO_W];
   assign dlink[0] = prep_ff;

   for (genvar b = 0; b < vnfbm_pkg::QUO_W; b++) begin : g_div
      vnfbm_div_cell #(
         .BIT(vnfbm_pkg::QUO_W - 1 - b)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .item_in  (dlink[b]),
         .item_out (dlink[b+1])
      );
   end

   // Sign, saturation and the output register.
   logic [vnfbm_pkg::QUO_W-1:0] qmag;

   always_comb begin
      qmag          = dlink[vnfbm_pkg::QUO_W].quo;
      rsp_tvalid_in = dlink[vnfbm_pkg::QUO_W].valid;
      if (dlink[vnfbm_pkg::QUO_W].neg) begin
         rsp_tdata_in = (qmag > vnfbm_pkg::QUO_MAX) ? 16'h8000 : 16'(-qmag);
      end else begin
         rsp_tdata_in = (qmag > vnfbm_pkg::QUO_W'(32767)) ? 16'h7FFF : qmag[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A result never appears in the cycle after reset.
   `VNFBM_ASSERT_ALWAYS(a_quiet_after_reset, clock, $past(reset) |-> !rsp_tvalid)
   // The first octave always contributes its full weight.
   `VNFBM_ASSERT(a_first_octave_norm, clock, reset, link[1].valid |-> link[1].norm != '0)
   // Normalisation bounds the quotient magnitude by one.
   `VNFBM_ASSERT(a_quotient_bound, clock, reset, dlink[vnfbm_pkg::QUO_W].valid |-> dlink[vnfbm_pkg::QUO_W].quo <= vnfbm_pkg::QUO_MAX)

endmodule
